/* rtl/uht_pkg.sv */
// uht_pkg: shared types, codes and sizes of the unique hash table unit
// no dependencies; imported by uht_ram users and the top level
package uht_pkg;

    localparam int SLOTS = 1024;
    localparam int IDX_W = $clog2(SLOTS);
    localparam int CNT_W = IDX_W + 1;
    localparam logic [CNT_W-1:0] LIMIT_RESET = CNT_W'(SLOTS - (SLOTS / 4));

    localparam logic [31:0] PROTECTED_COUNT = 32'hFFFF_FFFF;

    // command codes
    localparam logic [2:0] CMD_LOOKUP    = 3'd0;
    localparam logic [2:0] CMD_INSERT    = 3'd1;
    localparam logic [2:0] CMD_REF       = 3'd2;
    localparam logic [2:0] CMD_DEREF     = 3'd3;
    localparam logic [2:0] CMD_PROTECT   = 3'd4;
    localparam logic [2:0] CMD_UNPROTECT = 3'd5;
    localparam logic [2:0] CMD_SWEEP     = 3'd6;

    // result status codes
    localparam logic [2:0] RS_FOUND    = 3'd0;
    localparam logic [2:0] RS_INSERTED = 3'd1;
    localparam logic [2:0] RS_MISS     = 3'd2;
    localparam logic [2:0] RS_FULL     = 3'd3;
    localparam logic [2:0] RS_DONE     = 3'd4;

    // slot status codes
    localparam logic [1:0] ST_EMPTY = 2'd0;
    localparam logic [1:0] ST_LIVE  = 2'd1;
    localparam logic [1:0] ST_TOMB  = 2'd2;

    // one table entry as held in the data memory
    typedef struct packed {
        logic [31:0] hash;
        logic [63:0] key;
        logic [31:0] value;
        logic [31:0] refs;
    } t_entry;

    // result of one command before the counters are attached
    typedef struct packed {
        logic [2:0]       status;
        logic [31:0]      fval;
        logic [9:0]       fslot;
        logic [CNT_W-1:0] rec;
    } t_result;

endpackage

/* rtl/uht_ram.sv */
// uht_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module uht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/unique_hash_table_with_refcounts_unit.sv */
// Unique hash table with reference counts: open addressing, linear probing
// and tombstones. Depends on uht_pkg and uht_ram.
//
// One transaction at a time. After reset a clearing pass over all SLOTS (1024)
// slots marks every slot empty; no transaction is taken during it. Lookup and
// find-or-insert probe from the home slot (one status and entry read per cycle,
// up to SLOTS probes); ref, deref, protect and unprotect act on one slot; sweep
// visits every slot, one slot per cycle through the memories; unused codes
// return a done result. The probe walk over the slot memories sets the rate.
// A finished result sits in the output register while the next transaction is
// taken. The user must write load_limit only while idle; the block does not enforce it.
module unique_hash_table_with_refcounts_unit
    import uht_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_cfg_wr_en,
    input  logic [10:0]  i_cfg_wr_data,   // load_limit
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // command[2:0], key_hash[34:3], key_tag[98:35], entry_value[130:99],
    // slot_index[140:131], zero fill
    input  logic [143:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // status[2:0], found_value[34:3], found_slot[44:35], reclaimed[55:45],
    // over_threshold[56], live_entries[67:57], dead_entries[78:68], zero fill
    output logic [79:0]  o_m_tdata
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_PROBE, S_REFS, S_SWEEP, S_EMIT
    } t_state;

    t_state           r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_free_v, n_free_v;
    logic [IDX_W-1:0] r_free, n_free;
    logic [CNT_W-1:0] r_live, n_live;
    logic [CNT_W-1:0] r_tomb, n_tomb;
    logic [CNT_W-1:0] r_limit, n_limit;
    logic [CNT_W-1:0] r_rec, n_rec;
    logic [2:0]       r_cmd, n_cmd;
    logic [31:0]      r_hash, n_hash;
    logic [63:0]      r_key, n_key;
    logic [31:0]      r_value, n_value;
    t_result          r_res, n_res;
    logic             r_out_valid, n_out_valid;
    logic [79:0]      r_out_data, n_out_data;

    // memory ports
    logic             stat_we, data_we;
    logic [IDX_W-1:0] stat_waddr, data_waddr, raddr;
    logic [1:0]       stat_wdata, stat_rdata;
    t_entry           data_wdata, data_rdata;

    // input fields
    logic [2:0]       in_cmd;
    logic [IDX_W-1:0] in_home, in_slot;
    logic             s_acc;

    // probe helpers
    logic             hit;
    logic             have_free;
    logic [IDX_W-1:0] free_at;
    logic             free_tomb;
    logic [31:0]      new_refs;
    logic [CNT_W:0]   fill_sum;

    assign in_cmd  = i_s_tdata[2:0];
    assign in_home = i_s_tdata[3 +: IDX_W];
    assign in_slot = i_s_tdata[131 +: IDX_W];
    assign o_s_tready = (r_state == S_IDLE);
    assign s_acc = i_s_tvalid && o_s_tready;

    uht_ram #(.WIDTH(2), .DEPTH(SLOTS)) u_stat_ram (
        .i_clk   (i_clk),
        .i_we    (stat_we),
        .i_waddr (stat_waddr),
        .i_wdata (stat_wdata),
        .i_raddr (raddr),
        .o_rdata (stat_rdata)
    );

    uht_ram #(.WIDTH($bits(t_entry)), .DEPTH(SLOTS)) u_data_ram (
        .i_clk   (i_clk),
        .i_we    (data_we),
        .i_waddr (data_waddr),
        .i_wdata (data_wdata),
        .i_raddr (raddr),
        .o_rdata (data_rdata)
    );

    // probe decisions on the slot just read
    assign hit = (stat_rdata == ST_LIVE) && (data_rdata.hash == r_hash)
              && (data_rdata.key == r_key);
    assign have_free = r_free_v || (stat_rdata != ST_LIVE);
    assign free_at   = r_free_v ? r_free : r_idx;
    assign free_tomb = r_free_v || (stat_rdata == ST_TOMB);
    assign fill_sum  = {1'b0, r_live} + {1'b0, r_tomb};

    // new reference count for the refcount commands
    always_comb begin
        case (r_cmd)
            CMD_REF:
                new_refs = (data_rdata.refs == PROTECTED_COUNT) ? data_rdata.refs
                                                                : data_rdata.refs + 32'd1;
            CMD_DEREF:
                new_refs = (data_rdata.refs == PROTECTED_COUNT || data_rdata.refs == 32'd0)
                           ? data_rdata.refs : data_rdata.refs - 32'd1;
            CMD_PROTECT: new_refs = PROTECTED_COUNT;
            default:     new_refs = 32'd0;
        endcase
    end

    // next state, memory writes and results
    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_free_v    = r_free_v;
        n_free      = r_free;
        n_live      = r_live;
        n_tomb      = r_tomb;
        n_limit     = i_cfg_wr_en ? i_cfg_wr_data : r_limit;
        n_rec       = r_rec;
        n_cmd       = r_cmd;
        n_hash      = r_hash;
        n_key       = r_key;
        n_value     = r_value;
        n_res       = r_res;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_data  = r_out_data;
        stat_we     = 1'b0;
        stat_waddr  = r_idx;
        stat_wdata  = ST_EMPTY;
        data_we     = 1'b0;
        data_waddr  = r_idx;
        data_wdata  = data_rdata;
        raddr       = r_idx;

        unique case (r_state)
            S_CLEAR: begin
                stat_we = 1'b1;
                n_idx   = r_idx + 1'b1;
                if (&r_idx) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                n_cmd   = in_cmd;
                n_hash  = i_s_tdata[34:3];
                n_key   = i_s_tdata[98:35];
                n_value = i_s_tdata[130:99];
                n_res   = '{status: RS_DONE, fval: 32'd0, fslot: 10'd0, rec: '0};
                if (s_acc) begin
                    case (in_cmd)
                        CMD_LOOKUP, CMD_INSERT: begin
                            raddr    = in_home;
                            n_idx    = in_home;
                            n_cnt    = '0;
                            n_free_v = 1'b0;
                            n_state  = S_PROBE;
                        end
                        CMD_REF, CMD_DEREF, CMD_PROTECT, CMD_UNPROTECT: begin
                            raddr   = in_slot;
                            n_idx   = in_slot;
                            n_state = S_REFS;
                        end
                        CMD_SWEEP: begin
                            raddr   = '0;
                            n_idx   = '0;
                            n_rec   = '0;
                            n_state = S_SWEEP;
                        end
                        default: n_state = S_EMIT;
                    endcase
                end
            end
            S_PROBE: begin
                if (hit) begin
                    n_res.status = RS_FOUND;
                    n_res.fval   = data_rdata.value;
                    n_res.fslot  = 10'(r_idx);
                    n_state      = S_EMIT;
                end else if (stat_rdata == ST_EMPTY || (&r_cnt)) begin
                    // end of the probe path
                    n_state = S_EMIT;
                    if (r_cmd == CMD_LOOKUP) begin
                        n_res.status = RS_MISS;
                    end else if (!have_free) begin
                        n_res.status = RS_FULL;
                    end else begin
                        stat_we         = 1'b1;
                        stat_waddr      = free_at;
                        stat_wdata      = ST_LIVE;
                        data_we         = 1'b1;
                        data_waddr      = free_at;
                        data_wdata      = '{hash: r_hash, key: r_key, value: r_value,
                                            refs: 32'd0};
                        n_live          = r_live + 1'b1;
                        if (free_tomb && r_tomb != '0) begin
                            n_tomb = r_tomb - 1'b1;
                        end
                        n_res.status = RS_INSERTED;
                        n_res.fval   = r_value;
                        n_res.fslot  = 10'(free_at);
                    end
                end else begin
                    // step to the next slot, remember the first tombstone
                    if (!r_free_v && stat_rdata != ST_LIVE) begin
                        n_free_v = 1'b1;
                        n_free   = r_idx;
                    end
                    n_cnt = r_cnt + 1'b1;
                    n_idx = r_idx + 1'b1;
                    raddr = r_idx + 1'b1;
                end
            end
            S_REFS: begin
                n_res.fslot = 10'(r_idx);
                if (stat_rdata != ST_LIVE) begin
                    n_res.status = RS_MISS;
                end else begin
                    data_we         = 1'b1;
                    data_wdata.refs = new_refs;
                end
                n_state = S_EMIT;
            end
            S_SWEEP: begin
                if (stat_rdata == ST_LIVE && data_rdata.refs == 32'd0) begin
                    stat_we    = 1'b1;
                    stat_wdata = ST_TOMB;
                    n_tomb     = r_tomb + 1'b1;
                    if (r_live != '0) begin
                        n_live = r_live - 1'b1;
                    end
                    n_rec = r_rec + 1'b1;
                end
                n_res.rec = n_rec;
                n_idx     = r_idx + 1'b1;
                raddr     = r_idx + 1'b1;
                if (&r_idx) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_m_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = {1'b0, r_tomb, r_live,
                                   (fill_sum >= {1'b0, r_limit}),
                                   r_res.rec, r_res.fslot, r_res.fval, r_res.status};
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_live      <= '0;
            r_tomb      <= '0;
            r_limit     <= LIMIT_RESET;
            r_out_valid <= 1'b0;
            r_free_v    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_live      <= n_live;
            r_tomb      <= n_tomb;
            r_limit     <= n_limit;
            r_out_valid <= n_out_valid;
            r_free_v    <= n_free_v;
        end
        r_cnt      <= n_cnt;
        r_free     <= n_free;
        r_rec      <= n_rec;
        r_cmd      <= n_cmd;
        r_hash     <= n_hash;
        r_key      <= n_key;
        r_value    <= n_value;
        r_res      <= n_res;
        r_out_data <= n_out_data;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // occupancy never exceeds the table
    a_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fill_sum <= (CNT_W + 1)'(SLOTS))
        else $error("live plus tombstone count above table size");

    // an insert writes status and entry of the same slot
    a_same_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (data_we && stat_we) |-> (data_waddr == stat_waddr))
        else $error("status and entry written at different slots");

    // sweep cannot reclaim more slots than it has visited
    a_rec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> (r_rec <= {1'b0, r_idx}))
        else $error("sweep count ahead of sweep position");

    // no memory write while waiting for a transaction
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_EMIT) |-> (!stat_we && !data_we))
        else $error("memory written outside a command");

endmodule

/* tb/sv/tb.sv */
// testbench for unique_hash_table_with_refcounts_unit: random and directed table commands
// checked against an in-bench table predictor; depends on uht_pkg and the unit's rtl
`timescale 1ns / 1ps

module tb;
    import uht_pkg::*;

    // command code with no operation behind it
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    // scoreboard: predicted table state plus queue of expected result words
    class table_scoreboard;
        logic [1:0]  st[SLOTS];
        logic [31:0] hsh[SLOTS];
        logic [63:0] key[SLOTS];
        logic [31:0] val[SLOTS];
        logic [31:0] refs[SLOTS];
        int unsigned live_cnt;
        int unsigned tomb_cnt;
        logic [10:0] load_limit;
        logic [79:0] pending[$];
        int errors;

        function void clear();
            for (int i = 0; i < SLOTS; i++) begin
                st[i] = ST_EMPTY;
                hsh[i] = '0;
                key[i] = '0;
                val[i] = '0;
                refs[i] = '0;
            end
            live_cnt = 0;
            tomb_cnt = 0;
            load_limit = LIMIT_RESET;
            pending.delete();
            errors = 0;
        endfunction

        function int find_match(logic [31:0] h, logic [63:0] k);
            int idx;
            idx = h & (SLOTS - 1);
            for (int n = 0; n < SLOTS; n++) begin
                if (st[idx] == ST_EMPTY) return -1;
                if (st[idx] == ST_LIVE && hsh[idx] == h && key[idx] == k) return idx;
                idx = (idx + 1) & (SLOTS - 1);
            end
            return -1;
        endfunction

        function int find_free(logic [31:0] h);
            int idx;
            idx = h & (SLOTS - 1);
            for (int n = 0; n < SLOTS; n++) begin
                if (st[idx] != ST_LIVE) return idx;
                idx = (idx + 1) & (SLOTS - 1);
            end
            return -1;
        endfunction

        // apply one accepted command and queue its result
        function void note_command(logic [143:0] d);
            logic [2:0]  cmd;
            logic [31:0] h, v, fval;
            logic [63:0] k;
            logic [9:0]  si, fslot;
            logic [2:0]  status;
            logic [10:0] rec;
            int at;
            cmd = d[2:0];
            h = d[34:3];
            k = d[98:35];
            v = d[130:99];
            si = d[140:131];
            status = RS_DONE;
            fval = '0;
            fslot = '0;
            rec = '0;
            if (cmd == CMD_LOOKUP || cmd == CMD_INSERT) begin
                at = find_match(h, k);
                if (at >= 0) begin
                    status = RS_FOUND;
                    fval = val[at];
                    fslot = 10'(at);
                end else if (cmd == CMD_LOOKUP) begin
                    status = RS_MISS;
                end else begin
                    at = find_free(h);
                    if (at < 0) begin
                        status = RS_FULL;
                    end else begin
                        if (st[at] == ST_TOMB && tomb_cnt > 0) tomb_cnt--;
                        st[at] = ST_LIVE;
                        hsh[at] = h;
                        key[at] = k;
                        val[at] = v;
                        refs[at] = '0;
                        live_cnt++;
                        status = RS_INSERTED;
                        fval = v;
                        fslot = 10'(at);
                    end
                end
            end else if (cmd >= CMD_REF && cmd <= CMD_UNPROTECT) begin
                fslot = si;
                if (st[si] != ST_LIVE) begin
                    status = RS_MISS;
                end else begin
                    case (cmd)
                        CMD_REF: if (refs[si] != PROTECTED_COUNT) refs[si]++;
                        CMD_DEREF: begin
                            if (refs[si] != PROTECTED_COUNT && refs[si] != 0) refs[si]--;
                        end
                        CMD_PROTECT: refs[si] = PROTECTED_COUNT;
                        default: refs[si] = '0;
                    endcase
                end
            end else if (cmd == CMD_SWEEP) begin
                for (int i = 0; i < SLOTS; i++) begin
                    if (st[i] == ST_LIVE && refs[i] == 0) begin
                        st[i] = ST_TOMB;
                        hsh[i] = '0;
                        tomb_cnt++;
                        if (live_cnt > 0) live_cnt--;
                        rec++;
                    end
                end
            end
            pending.push_back({1'b0, 11'(tomb_cnt), 11'(live_cnt),
                               1'((live_cnt + tomb_cnt) >= load_limit),
                               rec, fslot, fval, status});
        endfunction

        // compare one result transaction with the oldest expectation
        function void check_result(logic [79:0] got);
            logic [79:0] exp;
            if (pending.size() == 0) begin
                $display("%0t unexpected result %h", $time, got);
                errors++;
                return;
            end
            exp = pending.pop_front();
            if (got[2:0] !== exp[2:0])
                $display("%0t status exp %0d got %0d", $time, exp[2:0], got[2:0]);
            if (got[34:3] !== exp[34:3])
                $display("%0t found_value exp %h got %h", $time, exp[34:3], got[34:3]);
            if (got[44:35] !== exp[44:35])
                $display("%0t found_slot exp %0d got %0d", $time, exp[44:35], got[44:35]);
            if (got[55:45] !== exp[55:45])
                $display("%0t reclaimed exp %0d got %0d", $time, exp[55:45], got[55:45]);
            if (got[56] !== exp[56])
                $display("%0t over_threshold exp %b got %b", $time, exp[56], got[56]);
            if (got[67:57] !== exp[67:57])
                $display("%0t live exp %0d got %0d", $time, exp[67:57], got[67:57]);
            if (got[78:68] !== exp[78:68])
                $display("%0t dead exp %0d got %0d", $time, exp[78:68], got[78:68]);
            if (got !== exp) errors++;
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_cfg_wr_en;
    logic [10:0]  i_cfg_wr_data;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [143:0] i_s_tdata;   // command, key_hash, key_tag, entry_value, slot_index
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [79:0]  o_m_tdata;   // status, found_value, found_slot, reclaimed, over, live, dead

    unique_hash_table_with_refcounts_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_wr_en(i_cfg_wr_en), .i_cfg_wr_data(i_cfg_wr_data),
        .i_s_tvalid(i_s_tvalid), .o_s_tready(o_s_tready), .i_s_tdata(i_s_tdata),
        .o_m_tvalid(o_m_tvalid), .i_m_tready(i_m_tready), .o_m_tdata(o_m_tdata)
    );

    table_scoreboard sb;
    int unsigned cycle_cnt;
    bit hold_rx;
    logic [31:0] hash_pool[8];
    logic [63:0] key_pool[16];

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // cycle limit
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > 4000000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // result side: random stall per transaction, long hold when requested
    initial begin
        int w;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if (hold_rx) begin
                i_m_tready <= 1'b0;
            end else if (i_m_tready && !o_m_tvalid) begin
                i_m_tready <= 1'b1;
            end else begin
                w = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
                if (w > 0 && $urandom_range(0, 2) != 0) begin
                    i_m_tready <= 1'b0;
                    repeat (w) @(posedge i_clk);
                end
                i_m_tready <= 1'b1;
            end
        end
    end

    // one command transaction; gap drawn 0..15
    task automatic send_cmd(logic [2:0] cmd, logic [31:0] h, logic [63:0] k,
                            logic [31:0] v, logic [9:0] si, bit gaps);
        int g;
        g = gaps ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15)) : 0;
        if (g > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata <= {3'b0, si, v, k, h, cmd};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        sb.note_command(i_s_tdata);
    endtask

    task automatic stop_sending();
        i_s_tvalid <= 1'b0;
    endtask

    task automatic drain();
        stop_sending();
        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_limit(logic [10:0] lim);
        i_cfg_wr_en <= 1'b1;
        i_cfg_wr_data <= lim;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        sb.load_limit = lim;
        @(posedge i_clk);
    endtask

    // random command mostly on a small key pool so hits and collisions occur
    task automatic random_cmd(bit gaps);
        int r, p;
        logic [2:0] cmd;
        logic [31:0] h;
        logic [63:0] k;
        logic [9:0] si;
        r = $urandom_range(0, 99);
        cmd = (r < 40) ? CMD_INSERT : (r < 60) ? CMD_LOOKUP : (r < 70) ? CMD_REF :
              (r < 80) ? CMD_DEREF : (r < 86) ? CMD_PROTECT : (r < 92) ? CMD_UNPROTECT :
              (r < 96) ? CMD_SWEEP : CMD_UNUSED;
        p = $urandom_range(0, 15);
        k = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom} : key_pool[p];
        h = ($urandom_range(0, 4) == 0) ? $urandom : hash_pool[p & 7];
        si = ($urandom_range(0, 1) == 0) ? 10'(h + $urandom_range(0, 3)) : 10'($urandom);
        send_cmd(cmd, h, k, $urandom, si, gaps);
    endtask

    initial begin
        logic [31:0] h0;
        sb = new();
        sb.clear();
        cycle_cnt = 0;
        hold_rx = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_wr_en = 1'b0;
        i_cfg_wr_data = '0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        for (int i = 0; i < 8; i++) hash_pool[i] = $urandom;
        for (int i = 0; i < 16; i++) key_pool[i] = {$urandom, $urandom};
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, every command, protected counts, misses
        write_limit(11'd1);
        h0 = 32'hFFFF_FFFF;
        send_cmd(CMD_LOOKUP, h0, '1, '1, '0, 0);
        send_cmd(CMD_INSERT, h0, '1, '1, '0, 0);
        send_cmd(CMD_INSERT, h0, '1, 32'h1, '0, 0);
        send_cmd(CMD_INSERT, h0, 64'h0, 32'h0, '0, 0);      // collision wraps to slot 0
        send_cmd(CMD_INSERT, 32'h0, 64'h5, 32'h5, '0, 0);
        send_cmd(CMD_LOOKUP, h0, 64'h0, '0, '0, 0);
        send_cmd(CMD_REF, '0, '0, '0, 10'h3FF, 0);
        send_cmd(CMD_DEREF, '0, '0, '0, 10'h3FF, 0);
        send_cmd(CMD_DEREF, '0, '0, '0, 10'h3FF, 0);        // deref at zero
        send_cmd(CMD_PROTECT, '0, '0, '0, 10'h0, 0);
        send_cmd(CMD_REF, '0, '0, '0, 10'h0, 0);
        send_cmd(CMD_DEREF, '0, '0, '0, 10'h0, 0);
        send_cmd(CMD_REF, '0, '0, '0, 10'h200, 0);          // slot not live
        send_cmd(CMD_UNPROTECT, '0, '0, '0, 10'h0, 0);
        send_cmd(CMD_REF, '0, '0, '0, 10'h1, 0);
        send_cmd(CMD_UNUSED, '1, '1, '1, '1, 0);
        send_cmd(CMD_SWEEP, '0, '0, '0, '0, 0);
        send_cmd(CMD_LOOKUP, h0, '1, '0, '0, 0);
        send_cmd(CMD_INSERT, h0, 64'h77, 32'hA5A5_5A5A, '0, 0); // reuse tombstone
        send_cmd(CMD_DEREF, '0, '0, '0, 10'h1, 0);
        send_cmd(CMD_SWEEP, '0, '0, '0, '0, 0);
        drain();

        // random phases under several load limits
        write_limit(11'd0);
        repeat (120) random_cmd(1);
        drain();
        write_limit(11'd2047);
        repeat (120) random_cmd(1);
        // long receiver hold while commands keep coming
        fork
            begin
                hold_rx = 1'b1;
                repeat (300) @(posedge i_clk);
                hold_rx = 1'b0;
            end
            repeat (20) random_cmd(0);
        join
        drain();
        write_limit(11'd8);
        repeat (120) random_cmd(1);
        drain();
        write_limit(11'd1024);
        send_cmd(CMD_INSERT, $urandom, {$urandom, $urandom}, '1, '0, 0);
        send_cmd(CMD_LOOKUP, $urandom, '1, '0, '0, 0);
        send_cmd(CMD_SWEEP, '0, '0, '0, '0, 0);
        repeat (150) random_cmd(1);
        drain();

        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

/* filelist.f */
rtl/uht_pkg.sv
rtl/uht_ram.sv
rtl/unique_hash_table_with_refcounts_unit.sv
tb/sv/tb.sv
